// ===== rtl/core/mldfa_pkg.sv =====
// ----------------------------------------------------------------------------
// Multi-lane DFA stepper package
// Shared constants, command and register codes, and beat payload types.
// ----------------------------------------------------------------------------
package mldfa_pkg;

    localparam int LANES_DEF       = 8;
    localparam int TABLE_DEPTH_DEF = 65536;
    localparam int STATE_BITS_DEF  = 8;

    // The beat payload always carries eight symbol and eight state fields.
    localparam int MAX_LANES = 8;
    localparam int SYM_W     = 8;
    localparam int OUT_W     = 8;
    localparam int COUNT_W   = 9;
    localparam int WIDX_W    = 16;
    localparam int WVAL_W    = 8;
    localparam int REG_IDX_W = 2;

    typedef enum logic [1:0] {
        CMD_WRITE_TABLE = 2'd0,
        CMD_SET_LANE    = 2'd1,
        CMD_STEP        = 2'd2
    } cmd_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_SYMBOL_COUNT = 2'd0,
        REG_STATE_COUNT  = 2'd1,
        REG_TABLE_LAYOUT = 2'd2
    } cfg_reg_t;

    localparam logic LAYOUT_STATE_MAJOR  = 1'b0;
    localparam logic LAYOUT_SYMBOL_MAJOR = 1'b1;

    localparam logic [COUNT_W-1:0] SYMBOL_COUNT_RST = 9'd256;
    localparam logic [COUNT_W-1:0] STATE_COUNT_RST  = 9'd256;
    localparam logic               TABLE_LAYOUT_RST = LAYOUT_STATE_MAJOR;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [WIDX_W-1:0] write_index;
        logic [WVAL_W-1:0] write_value;
        logic [SYM_W-1:0]  sym_0;
        logic [SYM_W-1:0]  sym_1;
        logic [SYM_W-1:0]  sym_2;
        logic [SYM_W-1:0]  sym_3;
        logic [SYM_W-1:0]  sym_4;
        logic [SYM_W-1:0]  sym_5;
        logic [SYM_W-1:0]  sym_6;
        logic [SYM_W-1:0]  sym_7;
    } step_item_t;

    typedef struct packed {
        logic [OUT_W-1:0] lane_state_0;
        logic [OUT_W-1:0] lane_state_1;
        logic [OUT_W-1:0] lane_state_2;
        logic [OUT_W-1:0] lane_state_3;
        logic [OUT_W-1:0] lane_state_4;
        logic [OUT_W-1:0] lane_state_5;
        logic [OUT_W-1:0] lane_state_6;
        logic [OUT_W-1:0] lane_state_7;
        logic             index_error;
    } result_item_t;

    typedef struct packed {
        logic [REG_IDX_W-1:0] index;
        logic [COUNT_W-1:0]   value;
    } cfg_write_t;

endpackage

// ===== rtl/core/mldfa_stream_if.sv =====
// ----------------------------------------------------------------------------
// Multi-lane DFA stepper stream interface
// Valid/ready channel carrying one payload beat of type T.
// ----------------------------------------------------------------------------
interface mldfa_stream_if #(
    parameter type T = logic
) ();

    logic valid;
    logic ready;
    T     data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );

endinterface

// ===== rtl/core/multi_lane_dfa_table_stepper.sv =====
// ----------------------------------------------------------------------------
// Multi-lane DFA table stepper
// Eight-lane table-driven automaton stepper with per-lane table copies.
// ----------------------------------------------------------------------------
// A step beat waits in the result stage (s1) while the lanes read their
// tables, then its lane states are captured into the output register.
// Throughput: one beat per cycle unless results stall; in each lane the
// state -> index -> table read loop closes through the registered read port.
// Reset clears all lane states to zero and sets symbol_count = 256,
// state_count = 256, table_layout = 0. The transition table is not cleared.
// ----------------------------------------------------------------------------
module multi_lane_dfa_table_stepper #(
    parameter int LANES       = mldfa_pkg::LANES_DEF,
    parameter int TABLE_DEPTH = mldfa_pkg::TABLE_DEPTH_DEF,
    parameter int STATE_BITS  = mldfa_pkg::STATE_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    mldfa_stream_if.sink     step,
    mldfa_stream_if.source   result,
    mldfa_stream_if.sink     cfg
);

    import mldfa_pkg::*;

    // Table address width and the width of the raw lane index. The index is
    // kept wide enough that neither layout can wrap before the bound check.
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int IW = STATE_BITS + 18;

    // ------------------------------------------------------------------
    // Configuration registers. The port is always ready; software must only
    // write them while the block is idle, which the block does not enforce.
    // ------------------------------------------------------------------
    logic [COUNT_W-1:0] symbol_count_reg;
    logic [COUNT_W-1:0] state_count_reg;
    logic               table_layout_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            symbol_count_reg <= SYMBOL_COUNT_RST;
            state_count_reg  <= STATE_COUNT_RST;
            table_layout_reg <= TABLE_LAYOUT_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg_reg_t'(cfg.data.index))
                REG_SYMBOL_COUNT: symbol_count_reg <= cfg.data.value;
                REG_STATE_COUNT:  state_count_reg  <= cfg.data.value;
                REG_TABLE_LAYOUT: table_layout_reg <= cfg.data.value[0];
                default:          ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake. A step beat goes into a one-beat result stage (s1) while
    // the lanes read their tables; once s1 drains, the lane states are
    // captured into the output register. The input is ready while s1 is
    // empty or can drain into the output register in the same cycle.
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic s1_error_reg;
    logic out_valid_reg;
    logic s1_move;
    logic accept;
    logic do_write;
    logic do_set;
    logic do_step;
    logic step_error;

    assign s1_move    = s1_valid_reg && (!out_valid_reg || result.ready);
    assign step.ready = !s1_valid_reg || s1_move;
    assign accept     = step.valid && step.ready;

    always_comb
    begin
        do_write = 1'b0;
        do_set   = 1'b0;
        do_step  = 1'b0;
        case (cmd_t'(step.data.cmd))
            CMD_WRITE_TABLE: do_write = accept;
            CMD_SET_LANE:    do_set   = accept;
            CMD_STEP:        do_step  = accept;
            default:         ;
        endcase
    end

    // Table writes land in every lane's copy; an index past the table is
    // dropped. The write value is fitted to the state width.
    logic                  tbl_we;
    logic [AW-1:0]         tbl_waddr;
    logic [STATE_BITS-1:0] tbl_wdata;
    logic [STATE_BITS-1:0] set_value;

    assign tbl_we    = do_write &&
                       ({1'b0, step.data.write_index} < (WIDX_W + 1)'(TABLE_DEPTH));
    assign tbl_waddr = AW'(step.data.write_index);
    assign tbl_wdata = STATE_BITS'(step.data.write_value);
    assign set_value = STATE_BITS'(step.data.write_value);

    logic [SYM_W-1:0] sym [MAX_LANES];

    assign sym[0] = step.data.sym_0;
    assign sym[1] = step.data.sym_1;
    assign sym[2] = step.data.sym_2;
    assign sym[3] = step.data.sym_3;
    assign sym[4] = step.data.sym_4;
    assign sym[5] = step.data.sym_5;
    assign sym[6] = step.data.sym_6;
    assign sym[7] = step.data.sym_7;

    // ------------------------------------------------------------------
    // Lanes. Each lane owns a full copy of the transition table, so all
    // lanes read in parallel through one read port each. A lane's current
    // state lives either in its table read register (after a good step)
    // or in its hold register (after reset, a set, or an out-of-range
    // step); the select bit says which one is live.
    // ------------------------------------------------------------------
    logic [STATE_BITS-1:0] cur_state [LANES];
    logic [LANES-1:0]      in_range;

    genvar k;
    generate
        for (k = 0; k < LANES; k++)
        begin : g_lane
            logic [STATE_BITS-1:0] mem [TABLE_DEPTH];
            logic [STATE_BITS-1:0] rdata_reg;
            logic [STATE_BITS-1:0] held_reg;
            logic [STATE_BITS-1:0] held_next;
            logic                  sel_reg;
            logic                  sel_next;
            logic [IW-1:0]         idx;
            logic                  rd_en;
            logic                  set_hit;

            assign cur_state[k] = sel_reg ? rdata_reg : held_reg;

            // One multiply and one add form the table index in either layout.
            always_comb
            begin
                if (table_layout_reg == LAYOUT_SYMBOL_MAJOR)
                begin
                    idx = IW'(sym[k]) * IW'(state_count_reg) + IW'(cur_state[k]);
                end
                else
                begin
                    idx = IW'(cur_state[k]) * IW'(symbol_count_reg) + IW'(sym[k]);
                end
            end

            assign in_range[k] = idx < IW'(TABLE_DEPTH);
            assign rd_en       = do_step && in_range[k];
            assign set_hit     = do_set && (step.data.write_index == WIDX_W'(k));

            always_ff @(posedge clk)
            begin
                if (tbl_we)
                begin
                    mem[tbl_waddr] <= tbl_wdata;
                end
                if (rd_en)
                begin
                    rdata_reg <= mem[AW'(idx)];
                end
            end

            always_comb
            begin
                held_next = held_reg;
                sel_next  = sel_reg;
                if (do_step)
                begin
                    if (in_range[k])
                    begin
                        sel_next = 1'b1;
                    end
                    else
                    begin
                        // Out-of-range step: the lane keeps its state.
                        held_next = cur_state[k];
                        sel_next  = 1'b0;
                    end
                end
                else if (set_hit)
                begin
                    held_next = set_value;
                    sel_next  = 1'b0;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    held_reg <= '0;
                    sel_reg  <= 1'b0;
                end
                else
                begin
                    held_reg <= held_next;
                    sel_reg  <= sel_next;
                end
            end
        end
    endgenerate

    assign step_error = do_step && !(&in_range);

    // ------------------------------------------------------------------
    // Result stage and output register. When s1 drains, the lane states
    // seen at that edge are exactly the results of the step held in s1,
    // since no later step can have been accepted in between.
    // ------------------------------------------------------------------
    logic [OUT_W-1:0] lane_out [MAX_LANES];
    logic [OUT_W-1:0] out_state_reg [MAX_LANES];
    logic             out_error_reg;

    generate
        for (k = 0; k < MAX_LANES; k++)
        begin : g_out
            if (k < LANES)
            begin : g_live
                assign lane_out[k] = OUT_W'(cur_state[k]);
            end
            else
            begin : g_unused
                assign lane_out[k] = '0;
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (do_step)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_step)
        begin
            s1_error_reg <= step_error;
        end
        if (s1_move)
        begin
            out_state_reg <= lane_out;
            out_error_reg <= s1_error_reg;
        end
    end

    assign result.valid             = out_valid_reg;
    assign result.data.lane_state_0 = out_state_reg[0];
    assign result.data.lane_state_1 = out_state_reg[1];
    assign result.data.lane_state_2 = out_state_reg[2];
    assign result.data.lane_state_3 = out_state_reg[3];
    assign result.data.lane_state_4 = out_state_reg[4];
    assign result.data.lane_state_5 = out_state_reg[5];
    assign result.data.lane_state_6 = out_state_reg[6];
    assign result.data.lane_state_7 = out_state_reg[7];
    assign result.data.index_error  = out_error_reg;

endmodule

// ===== sim/dfa_step_checker.sv =====
// ----------------------------------------------------------------------------
// Multi-lane DFA stepper checker
// Watches the step, result and register channels, keeps its own copy of the
// transition table, lane states and registers, and compares every result beat.
// ----------------------------------------------------------------------------
module dfa_step_checker
    import mldfa_pkg::*;
#(
    parameter int LANES       = LANES_DEF,
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int STATE_BITS  = STATE_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step_valid,
    input  logic         step_ready,
    input  step_item_t   step_data,
    input  logic         result_valid,
    input  logic         result_ready,
    input  result_item_t result_data,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  cfg_write_t   cfg_data,
    output int           fail_count,
    output int           outstanding,
    output int           beats_checked,
    output int           error_beats
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RES_W = $bits(result_item_t);

    logic [STATE_BITS-1:0] dfa_table [TABLE_DEPTH];
    logic [STATE_BITS-1:0] lane_st [LANES];
    logic [COUNT_W-1:0]    sym_cnt;
    logic [COUNT_W-1:0]    st_cnt;
    logic                  layout;
    result_item_t          lane_results_due [$];
    int                    fails;
    int                    checked;
    int                    flagged;

    function automatic void note_mismatch(string field, logic [OUT_W-1:0] want,
                                          logic [OUT_W-1:0] got);
        $error("%s: expected %0d, got %0d", field, want, got);
        fails++;
    endfunction

    function automatic void apply_register(cfg_write_t w);
        case (w.index)
            REG_SYMBOL_COUNT: sym_cnt = w.value;
            REG_STATE_COUNT:  st_cnt  = w.value;
            REG_TABLE_LAYOUT: layout  = w.value[0];
            default:          ;
        endcase
    endfunction

    // Updates the table or a lane on write and set beats; on a step beat it
    // moves every lane through the table and queues the lane states it shows.
    function automatic void advance_lanes(step_item_t beat);
        logic [SYM_W-1:0] syms [MAX_LANES];
        result_item_t     want;
        int unsigned      idx;
        logic             err;
        syms[0] = beat.sym_0;
        syms[1] = beat.sym_1;
        syms[2] = beat.sym_2;
        syms[3] = beat.sym_3;
        syms[4] = beat.sym_4;
        syms[5] = beat.sym_5;
        syms[6] = beat.sym_6;
        syms[7] = beat.sym_7;
        want = '0;
        err  = 1'b0;
        case (beat.cmd)
            CMD_WRITE_TABLE:
            begin
                if (32'(beat.write_index) < TABLE_DEPTH)
                begin
                    dfa_table[beat.write_index] = STATE_BITS'(beat.write_value);
                end
            end
            CMD_SET_LANE:
            begin
                if (32'(beat.write_index) < LANES)
                begin
                    lane_st[beat.write_index] = STATE_BITS'(beat.write_value);
                end
            end
            CMD_STEP:
            begin
                for (int k = 0; k < MAX_LANES; k++)
                begin
                    if (k < LANES)
                    begin
                        if (layout == LAYOUT_STATE_MAJOR)
                        begin
                            idx = 32'(lane_st[k]) * 32'(sym_cnt) + 32'(syms[k]);
                        end
                        else
                        begin
                            idx = 32'(syms[k]) * 32'(st_cnt) + 32'(lane_st[k]);
                        end
                        // A lane whose index runs past the table keeps its state.
                        if (idx < TABLE_DEPTH)
                        begin
                            lane_st[k] = dfa_table[idx];
                        end
                        else
                        begin
                            err = 1'b1;
                        end
                        want[RES_W-1-OUT_W*k -: OUT_W] = OUT_W'(lane_st[k]);
                    end
                end
                want.index_error = err;
                lane_results_due.push_back(want);
            end
            default: ;
        endcase
    endfunction

    function automatic void compare_beat(result_item_t got);
        result_item_t want;
        if (lane_results_due.size() == 0)
        begin
            $error("result beat arrived with no step awaiting it");
            fails++;
            return;
        end
        want = lane_results_due.pop_front();
        checked++;
        if (got.index_error === 1'b1)
        begin
            flagged++;
        end
        // Lane k sits k bytes below the top of the packed result.
        for (int k = 0; k < MAX_LANES; k++)
        begin
            if (got[RES_W-1-OUT_W*k -: OUT_W] !== want[RES_W-1-OUT_W*k -: OUT_W])
            begin
                note_mismatch($sformatf("lane_state_%0d", k),
                              want[RES_W-1-OUT_W*k -: OUT_W],
                              got[RES_W-1-OUT_W*k -: OUT_W]);
            end
        end
        if (got.index_error !== want.index_error)
        begin
            note_mismatch("index_error", OUT_W'(want.index_error), OUT_W'(got.index_error));
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LANES; k++)
            begin
                lane_st[k] = '0;
            end
            sym_cnt = SYMBOL_COUNT_RST;
            st_cnt  = STATE_COUNT_RST;
            layout  = TABLE_LAYOUT_RST;
            lane_results_due.delete();
            fails   = 0;
            checked = 0;
            flagged = 0;
        end
        else
        begin
            // Results first, so a beat can never match a step of the same edge.
            if (result_valid && result_ready)
            begin
                compare_beat(result_data);
            end
            if (cfg_valid && cfg_ready)
            begin
                apply_register(cfg_data);
            end
            if (step_valid && step_ready)
            begin
                advance_lanes(step_data);
            end
        end
        fail_count    <= fails;
        outstanding   <= lane_results_due.size();
        beats_checked <= checked;
        error_beats   <= flagged;
    end

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// Multi-lane DFA stepper testbench
// Runs phases that each pick registers and a small set of states and symbols,
// write every table entry those can reach, reseed the lanes and then mix
// steps, lane sets, table rewrites and unused commands, with random idling on
// both channels and one long result stall.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mldfa_pkg::*;

    localparam int CYCLE_LIMIT     = 1_000_000;
    // Settling time after the last result for a trailing write or set in flight.
    localparam int DRAIN_CYCLES    = 4;
    localparam int HOLD_CYCLES     = 200;
    localparam int RANDOM_PHASES   = 8;
    localparam int DIRECTED_BEATS  = 30;
    localparam int BEATS_PER_PHASE = 110;
    localparam int SET_SIZE        = 4;

    // Codes outside the defined sets, used to check that they are ignored.
    localparam logic [1:0]           CMD_UNUSED = 2'd3;
    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic clk        = 1'b0;
    logic rst_n      = 1'b0;
    logic burst_mode = 1'b0;
    logic hold_req   = 1'b0;
    logic hold_taken = 1'b0;
    int   cycle_count = 0;
    int   settings_done = 0;

    int   fail_count;
    int   outstanding;
    int   beats_checked;
    int   error_beats;

    // The states and symbols one phase works with. Every table entry they
    // can reach holds a state of the set, so the lanes never leave it.
    logic [WVAL_W-1:0] state_set  [SET_SIZE];
    logic [SYM_W-1:0]  symbol_set [SET_SIZE];

    mldfa_stream_if #(.T(step_item_t))   step_if ();
    mldfa_stream_if #(.T(result_item_t)) result_if ();
    mldfa_stream_if #(.T(cfg_write_t))   cfg_if ();

    multi_lane_dfa_table_stepper u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step_if),
        .result (result_if),
        .cfg    (cfg_if)
    );

    dfa_step_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .step_valid    (step_if.valid),
        .step_ready    (step_if.ready),
        .step_data     (step_if.data),
        .result_valid  (result_if.valid),
        .result_ready  (result_if.ready),
        .result_data   (result_if.data),
        .cfg_valid     (cfg_if.valid),
        .cfg_ready     (cfg_if.ready),
        .cfg_data      (cfg_if.data),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .beats_checked (beats_checked),
        .error_beats   (error_beats)
    );

    always #5 clk = ~clk;

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // In burst mode neither side idles, so the block runs at full rate.
    function automatic int draw_gap();
        return burst_mode ? 0 : int'($urandom_range(0, 3));
    endfunction

    function automatic step_item_t make_beat(logic [1:0] cmd, logic [WIDX_W-1:0] widx,
                                             logic [WVAL_W-1:0] wval, logic [63:0] syms);
        step_item_t b;
        b             = '0;
        b.cmd         = cmd;
        b.write_index = widx;
        b.write_value = wval;
        // The eight symbols fill the low 64 bits, lane 0 in the top byte.
        b[63:0]       = syms;
        return b;
    endfunction

    // Table index of a state and a symbol; it may run past the table.
    function automatic int unsigned lookup_index(logic [COUNT_W-1:0] sc,
                                                 logic [COUNT_W-1:0] st, logic lay,
                                                 logic [WVAL_W-1:0] s, logic [SYM_W-1:0] a);
        int unsigned idx;
        if (lay == LAYOUT_SYMBOL_MAJOR)
        begin
            idx = 32'(a) * 32'(st) + 32'(s);
        end
        else
        begin
            idx = 32'(s) * 32'(sc) + 32'(a);
        end
        return idx;
    endfunction

    function automatic logic [WVAL_W-1:0] pick_state();
        return state_set[$urandom_range(0, SET_SIZE - 1)];
    endfunction

    function automatic logic [SYM_W-1:0] pick_symbol();
        return symbol_set[$urandom_range(0, SET_SIZE - 1)];
    endfunction

    function automatic logic [63:0] pick_syms();
        logic [63:0] s;
        for (int k = 0; k < MAX_LANES; k++)
        begin
            s[63-8*k -: 8] = pick_symbol();
        end
        return s;
    endfunction

    // Register values: both ends of the legal range, zero, the widest
    // value the field holds, and random legal ones.
    function automatic logic [COUNT_W-1:0] pick_count();
        case ($urandom_range(0, 5))
            0:       return 9'd1;
            1:       return 9'd256;
            2:       return 9'd511;
            3:       return 9'd0;
            default: return 9'($urandom_range(1, 256));
        endcase
    endfunction

    // One step-channel beat: an idle gap drawn per beat, then valid held
    // until the block takes it. Valid stays high into the next beat when
    // that beat draws no gap.
    task automatic send_beat(input step_item_t beat);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            step_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        step_if.valid <= 1'b1;
        step_if.data  <= beat;
        do @(posedge clk); while (!step_if.ready);
    endtask

    task automatic cfg_beat(input logic [REG_IDX_W-1:0] idx, input logic [COUNT_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= '{index: idx, value: val};
        do @(posedge clk); while (!cfg_if.ready);
    endtask

    // Writes all three registers plus one index past the list, which the
    // block must ignore. Only called while the block is idle.
    task automatic program_regs(input logic [COUNT_W-1:0] sc, input logic [COUNT_W-1:0] st,
                                input logic lay);
        cfg_beat(REG_UNUSED, 9'($urandom));
        cfg_beat(REG_SYMBOL_COUNT, sc);
        cfg_beat(REG_STATE_COUNT, st);
        cfg_beat(REG_TABLE_LAYOUT, 9'(lay));
        cfg_if.valid <= 1'b0;
        settings_done++;
    endtask

    // Waits for every queued result, then lets any write or set in flight
    // settle before registers change.
    task automatic wait_idle();
        step_if.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One phase under the given registers: write every in-table entry of the
    // current states and symbols, reseed all lanes, then mostly steps with
    // some lane sets, table rewrites and unused commands. Straight after
    // reset one step runs before the reseed, on the reset lane state zero,
    // which the first state set holds.
    task automatic run_phase(input logic [COUNT_W-1:0] sc, input logic [COUNT_W-1:0] st,
                             input logic lay, input bit from_reset, input int beats);
        int unsigned       idx;
        int                roll;
        logic [WIDX_W-1:0] lane;
        for (int i = 0; i < SET_SIZE; i++)
        begin
            for (int j = 0; j < SET_SIZE; j++)
            begin
                idx = lookup_index(sc, st, lay, state_set[i], symbol_set[j]);
                if (idx < TABLE_DEPTH_DEF)
                begin
                    send_beat(make_beat(CMD_WRITE_TABLE, WIDX_W'(idx), pick_state(),
                                        {$urandom, $urandom}));
                end
            end
        end
        if (from_reset)
        begin
            send_beat(make_beat(CMD_STEP, 16'($urandom), 8'($urandom), pick_syms()));
        end
        for (int k = 0; k < LANES_DEF; k++)
        begin
            send_beat(make_beat(CMD_SET_LANE, WIDX_W'(k), pick_state(), {$urandom, $urandom}));
        end
        for (int n = 0; n < beats; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 75)
            begin
                send_beat(make_beat(CMD_STEP, 16'($urandom), 8'($urandom), pick_syms()));
            end
            else if (roll < 85)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    // Lane numbers past the last lane must leave every lane alone.
                    lane = WIDX_W'($urandom_range(LANES_DEF, 65535));
                    send_beat(make_beat(CMD_SET_LANE, lane, 8'($urandom), {$urandom, $urandom}));
                end
                else
                begin
                    lane = WIDX_W'($urandom_range(0, LANES_DEF - 1));
                    send_beat(make_beat(CMD_SET_LANE, lane, pick_state(), {$urandom, $urandom}));
                end
            end
            else if (roll < 95)
            begin
                idx = lookup_index(sc, st, lay, pick_state(), pick_symbol());
                if (idx < TABLE_DEPTH_DEF)
                begin
                    send_beat(make_beat(CMD_WRITE_TABLE, WIDX_W'(idx), pick_state(),
                                        {$urandom, $urandom}));
                end
                else
                begin
                    send_beat(make_beat(CMD_UNUSED, 16'($urandom), 8'($urandom),
                                        {$urandom, $urandom}));
                end
            end
            else
            begin
                send_beat(make_beat(CMD_UNUSED, 16'($urandom), 8'($urandom),
                                    {$urandom, $urandom}));
            end
        end
    endtask

    // Result side: a random hold-off per beat, and once a long stall that
    // backs the block up until it refuses step beats.
    initial
    begin
        int gap;
        result_if.ready <= 1'b0;
        wait (rst_n);
        forever
        begin
            gap = draw_gap();
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                gap        = HOLD_CYCLES;
            end
            if (gap > 0)
            begin
                result_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result_if.ready <= 1'b1;
            do @(posedge clk); while (!result_if.valid);
        end
    end

    initial
    begin
        int                 state_hi;
        logic [COUNT_W-1:0] sc;
        logic [COUNT_W-1:0] st;
        logic               lay;

        step_if.valid <= 1'b0;
        step_if.data  <= '0;
        cfg_if.valid  <= 1'b0;
        cfg_if.data   <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Reset registers (256 symbols, 256 states, state-major). The corner
        // states and symbols reach the first and the very last table entry.
        state_set  = '{8'd0, 8'd1, 8'd254, 8'd255};
        symbol_set = '{8'd0, 8'd1, 8'd254, 8'd255};
        run_phase(SYMBOL_COUNT_RST, STATE_COUNT_RST, TABLE_LAYOUT_RST, 1'b1, DIRECTED_BEATS);

        // A row stride of 511: high states index past the end of the table,
        // so those lanes hold and the error flag rises.
        wait_idle();
        program_regs(9'd511, 9'd511, LAYOUT_STATE_MAJOR);
        state_set  = '{8'd0, 8'd1, 8'd200, 8'd255};
        symbol_set = '{8'd0, 8'd7, 8'd128, 8'd255};
        run_phase(9'd511, 9'd511, LAYOUT_STATE_MAJOR, 1'b0, DIRECTED_BEATS);

        // Symbol-major with the widest state stride: high symbols overflow,
        // symbol 0 indexes by state alone.
        wait_idle();
        program_regs(9'd0, 9'd511, LAYOUT_SYMBOL_MAJOR);
        state_set  = '{8'd0, 8'd3, 8'd100, 8'd255};
        symbol_set = '{8'd0, 8'd1, 8'd200, 8'd255};
        run_phase(9'd0, 9'd511, LAYOUT_SYMBOL_MAJOR, 1'b0, DIRECTED_BEATS);

        // A state stride of zero collapses the index to the state itself.
        wait_idle();
        program_regs(9'd1, 9'd0, LAYOUT_SYMBOL_MAJOR);
        state_set  = '{8'd0, 8'd5, 8'd17, 8'd255};
        symbol_set = '{8'd0, 8'd9, 8'd99, 8'd255};
        run_phase(9'd1, 9'd0, LAYOUT_SYMBOL_MAJOR, 1'b0, DIRECTED_BEATS);

        // Random phases with new registers and new state and symbol sets,
        // alternately narrow and spread over the full byte range.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            wait_idle();
            burst_mode <= (p % 4 == 1);
            sc  = pick_count();
            st  = pick_count();
            lay = 1'($urandom_range(0, 1));
            program_regs(sc, st, lay);
            state_hi = (p % 2 == 0) ? 31 : 255;
            for (int i = 0; i < SET_SIZE; i++)
            begin
                state_set[i]  = WVAL_W'($urandom_range(0, state_hi));
                symbol_set[i] = SYM_W'($urandom_range(0, state_hi));
            end
            // One phase carries the long result stall while steps keep coming.
            if (p == 2)
            begin
                hold_req <= 1'b1;
            end
            run_phase(sc, st, lay, 1'b0, BEATS_PER_PHASE);
        end

        wait_idle();
        $display("Checked %0d result beats over %0d register settings, %0d with index errors.",
                 beats_checked, settings_done, error_beats);
        $display("Covered table corners, both layouts, lane reseeds, ignored codes and a %0d-cycle stall.",
                 HOLD_CYCLES);
        if (fail_count == 0 && outstanding == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/mldfa_pkg.sv
rtl/core/mldfa_stream_if.sv
rtl/core/multi_lane_dfa_table_stepper.sv
sim/dfa_step_checker.sv
sim/tb.sv
